// File: hw/rtl/lkvc_pkg.sv
// shared constants and controller/datapath interface types for the lru key/value cache
package lkvc_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int CAP_RESET    = 16;
    localparam int CFG_W        = 5;
    localparam int DATA_W       = 32;

    localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

    typedef struct packed {
        logic capture;
        logic exec;
        logic respond;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/lkvc_ram.sv
// generic single write port ram with registered read-first read port
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/lkvc_ctrl.sv
// sequencing state machine for the lru key/value cache
module lkvc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lkvc_pkg::t_status i_status,
    output lkvc_pkg::t_cmd    o_cmd
);
    import lkvc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   capture;

    assign in_ready = (r_state == S_IDLE) || ((r_state == S_RESP) && i_status.out_free);
    assign capture  = i_in_valid && in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    n_state = capture ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = in_ready;
    assign o_cmd.capture = capture;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.respond = (r_state == S_RESP) && i_status.out_free;

endmodule

// File: hw/rtl/lkvc_datapath.sv
// entry array, parallel key match, recency ranks and result register
module lkvc_datapath #(
    parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic        [lkvc_pkg::CFG_W-1:0]  i_cfg_data,
    input  lkvc_pkg::t_cmd                     i_cmd,
    output lkvc_pkg::t_status                  o_status,
    input  logic                               i_mode,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_write_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_read_value,
    output logic                               o_evicted,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_evicted_key
);
    import lkvc_pkg::*;

    localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW       = $clog2(CAPACITY + 1);
    localparam int CAP_INIT = (CAP_RESET > CAPACITY) ? CAPACITY : CAP_RESET;

    logic              r_mode;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_wval;
    logic [OW-1:0]     r_cap;
    logic [OW-1:0]     r_occ;
    logic [DATA_W-1:0] r_key_q [CAPACITY];
    logic [IW-1:0]     r_rank  [CAPACITY];
    logic              r_res_mode;
    logic              r_res_hit;
    logic              r_res_evict;
    logic              r_out_valid;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_rd;
    logic              r_out_ev;
    logic [DATA_W-1:0] r_out_evk;

    logic [CAPACITY-1:0] valid;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] oldest;
    logic [IW-1:0]       hit_idx;
    logic [IW-1:0]       victim_idx;
    logic [IW-1:0]       hit_rank;
    logic [IW-1:0]       slot;
    logic [OW-1:0]       occ_m1;
    logic [OW-1:0]       cap_new;
    logic                hit;
    logic                need_evict;
    logic                put_miss;
    logic [DATA_W-1:0]   val_rd;
    logic [DATA_W-1:0]   key_rd;

    // capacity write with zero and upper saturation
    always_comb begin
        if (i_cfg_data == '0) begin
            cap_new = OW'(1);
        end else if (32'(i_cfg_data) > 32'(CAPACITY)) begin
            cap_new = OW'(CAPACITY);
        end else begin
            cap_new = OW'(i_cfg_data);
        end
    end

    assign occ_m1 = r_occ - OW'(1);

    // valid entries always occupy slots 0 .. occupancy-1
    always_comb begin
        hit_idx    = '0;
        victim_idx = '0;
        hit_rank   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            valid[i]  = i < int'(r_occ);
            match[i]  = valid[i] && (r_key_q[i] == r_key);
            oldest[i] = valid[i] && (r_rank[i] == occ_m1[IW-1:0]);
            if (match[i]) begin
                hit_idx  = hit_idx | IW'(i);
                hit_rank = hit_rank | r_rank[i];
            end
            if (oldest[i]) begin
                victim_idx = victim_idx | IW'(i);
            end
        end
    end

    assign hit        = |match;
    assign need_evict = r_occ >= r_cap;
    assign put_miss   = r_mode && !hit;
    assign slot       = need_evict ? victim_idx : r_occ[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= OW'(CAP_INIT);
            r_occ <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= cap_new;
            end
            if (i_cmd.exec && put_miss && !need_evict) begin
                r_occ <= r_occ + OW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_wval <= i_write_value;
        end
        if (i_cmd.exec) begin
            r_res_mode  <= r_mode;
            r_res_hit   <= hit;
            r_res_evict <= put_miss && need_evict;
            for (int i = 0; i < CAPACITY; i++) begin
                if (hit) begin
                    if (IW'(i) == hit_idx) begin
                        r_rank[i] <= '0;
                    end else if (valid[i] && (r_rank[i] < hit_rank)) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end else if (put_miss) begin
                    if (IW'(i) == slot) begin
                        r_rank[i]  <= '0;
                        r_key_q[i] <= r_key;
                    end else if (valid[i]) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
            end
        end
    end

    lkvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && r_mode),
        .i_waddr (hit ? hit_idx : slot),
        .i_wdata (r_wval),
        .i_re    (i_cmd.exec),
        .i_raddr (hit_idx),
        .o_rdata (val_rd)
    );

    lkvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && put_miss),
        .i_waddr (slot),
        .i_wdata (r_key),
        .i_re    (i_cmd.exec),
        .i_raddr (victim_idx),
        .o_rdata (key_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.respond) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_out_hit <= r_res_hit;
            r_out_ev  <= r_res_evict;
            if (r_res_mode) begin
                r_out_rd <= '0;
            end else begin
                r_out_rd <= r_res_hit ? val_rd : MISS_VALUE;
            end
            r_out_evk <= r_res_evict ? key_rd : '0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_read_value      = r_out_rd;
    assign o_evicted         = r_out_ev;
    assign o_evicted_key     = r_out_evk;

endmodule

// File: hw/rtl/lru_key_value_cache_top.sv
// top level of the fully associative lru key/value cache
// beat to result: capture, match and update, then result load once the output register is free
// no new beat is taken during match and update, whose ram reads are registered for the result load
// a new beat is taken in the result load cycle whenever the output register is free
// reset: synchronous active low; empties the cache and sets capacity_in_use to min(16, CAPACITY)
// no clearing pass; the cache accepts beats in the first cycle after reset
module lru_key_value_cache_top #(
    parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic        [lkvc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_mode,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_write_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_read_value,
    output logic                               o_evicted,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_evicted_key
);
    import lkvc_pkg::*;

    t_cmd    s_cmd;
    t_status s_status;

    lkvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    lkvc_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (s_cmd),
        .o_status      (s_status),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    a_capture_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.capture |=> s_cmd.exec)
        else $error("accepted beat not processed in the next cycle");

    a_respond_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.respond |=> o_out_valid)
        else $error("result load did not raise output valid");

    a_evict_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> !o_hit)
        else $error("eviction reported on a hit");

    a_no_exec_while_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.exec |-> !o_in_ready)
        else $error("input ready while an item is being processed");

endmodule

// File: bench/lkvc_tb_pkg.sv
`timescale 1ns / 1ps
// operation codes shared by the lru cache testbench and its checker
package lkvc_tb_pkg;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

endpackage

// File: bench/lkvc_checker.sv
`timescale 1ns / 1ps
// lru cache checker: tracks the cache contents, predicts every result beat and compares it
module lkvc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_mode,
    input  logic [lkvc_pkg::DATA_W-1:0]       i_key,
    input  logic [lkvc_pkg::DATA_W-1:0]       i_write_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_hit,
    input  logic [lkvc_pkg::DATA_W-1:0]       i_read_value,
    input  logic                              i_evicted,
    input  logic [lkvc_pkg::DATA_W-1:0]       i_evicted_key,
    output int                                o_fail_count,
    output int                                o_pending
);
    import lkvc_tb_pkg::*;

    localparam int SLOTS = lkvc_pkg::CAPACITY_DEF;
    localparam int W     = lkvc_pkg::DATA_W;

    typedef struct packed {
        logic         hit;
        logic [W-1:0] rdata;
        logic         evicted;
        logic [W-1:0] ekey;
    } t_lookup;

    logic         slot_used [SLOTS];
    logic [W-1:0] slot_key  [SLOTS];
    logic [W-1:0] slot_data [SLOTS];
    logic [3:0]   slot_age  [SLOTS];
    int           fill_count;
    int           cap_limit;
    t_lookup      lookup_q [$];
    int           fail_total = 0;
    int           result_no  = 0;

    // entry becomes most recent, the ones more recent than it age by one
    task automatic promote(input int idx);
        logic [3:0] r;
        r = slot_age[idx];
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_age[i] < r) begin
                slot_age[i] = slot_age[i] + 4'(1);
            end
        end
        slot_age[idx] = '0;
    endtask

    task automatic predict_lookup(input t_op op, input logic [W-1:0] k, input logic [W-1:0] v,
                                  output t_lookup res);
        int found;
        int slot;
        found = -1;
        slot  = -1;
        res   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (found < 0 && slot_used[i] && slot_key[i] == k) begin
                found = i;
            end
        end
        if (op == OP_GET) begin
            if (found >= 0) begin
                res.hit   = 1'b1;
                res.rdata = slot_data[found];
                promote(found);
            end else begin
                res.rdata = lkvc_pkg::MISS_VALUE;
            end
        end else if (found >= 0) begin
            res.hit = 1'b1;
            slot_data[found] = v;
            promote(found);
        end else begin
            if (fill_count >= cap_limit) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i] && (slot < 0 || slot_age[i] > slot_age[slot])) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    res.evicted     = 1'b1;
                    res.ekey        = slot_key[slot];
                    slot_used[slot] = 1'b0;
                    fill_count--;
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (slot < 0 && !slot_used[i]) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i]) begin
                        slot_age[i] = slot_age[i] + 4'(1);
                    end
                end
                slot_used[slot] = 1'b1;
                slot_key[slot]  = k;
                slot_data[slot] = v;
                slot_age[slot]  = '0;
                fill_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup want;
        t_lookup seen;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
            end
            fill_count = 0;
            cap_limit  = lkvc_pkg::CAP_RESET;
            lookup_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_data == '0) begin
                    cap_limit = 1;
                end else if (int'(i_cfg_data) > SLOTS) begin
                    cap_limit = SLOTS;
                end else begin
                    cap_limit = int'(i_cfg_data);
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_lookup(t_op'(i_mode), i_key, i_write_value, want);
                lookup_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                seen.hit     = i_hit;
                seen.rdata   = i_read_value;
                seen.evicted = i_evicted;
                seen.ekey    = i_evicted_key;
                if (lookup_q.size() == 0) begin
                    if (fail_total < 10) begin
                        $display("result beat %0d arrived with none outstanding", result_no);
                    end
                    fail_total++;
                end else begin
                    want = lookup_q.pop_front();
                    if (seen !== want) begin
                        if (fail_total < 10) begin
                            $display("result beat %0d: want hit %0b read %h evicted %0b key %h,",
                                     result_no, want.hit, want.rdata, want.evicted, want.ekey,
                                     " got hit %0b read %h evicted %0b key %h",
                                     seen.hit, seen.rdata, seen.evicted, seen.ekey);
                        end
                        fail_total++;
                    end
                end
                result_no++;
            end
        end
        o_pending    <= lookup_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// testbench top for the lru key/value cache: drives get/put beats and capacity writes and reports the verdict
module tb;
    import lkvc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL        = 24;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 153;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [4:0]  cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        mode        = 1'b0;
    logic [31:0] key         = '0;
    logic [31:0] write_value = '0;
    logic        out_valid;
    logic        out_ready   = 1'b1;
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;

    int          fail_count;
    int          pending;
    int          gap_pct     = 0;
    int          stall_pct   = 0;
    int          stall_left  = 0;
    int          cycle_count = 0;
    bit          valid_on    = 1'b0;
    logic [31:0] key_pool [POOL];
    int          pct_choice [3] = '{0, 20, 50};

    lru_key_value_cache_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_mode        (mode),
        .i_key         (key),
        .i_write_value (write_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_hit         (hit),
        .o_read_value  (read_value),
        .o_evicted     (evicted),
        .o_evicted_key (evicted_key)
    );

    lkvc_checker result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_mode        (mode),
        .i_key         (key),
        .i_write_value (write_value),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_hit         (hit),
        .i_read_value  (read_value),
        .i_evicted     (evicted),
        .i_evicted_key (evicted_key),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lru_key_value_cache_top: mismatch");
            $finish;
        end
    end

    // result side back-pressure in bursts of random length
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 5);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic drop_valid();
        if (valid_on) begin
            in_valid <= 1'b0;
            valid_on = 1'b0;
        end
    endtask

    task automatic send_beat(input t_op op, input logic [31:0] k, input logic [31:0] v);
        in_valid    <= 1'b1;
        valid_on    = 1'b1;
        mode        <= op;
        key         <= k;
        write_value <= v;
        do @(posedge clk); while (!in_ready);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            drop_valid();
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // sender holds off until the cache has returned every outstanding result
    task automatic drain();
        drop_valid();
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_capacity(input logic [4:0] cap);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [4:0]  cap_plan [PHASES];
        int          eff;
        int          span;
        t_op         op;
        logic [31:0] k;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL; i++) begin
            key_pool[i] = $urandom;
        end
        cap_plan = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd2, 5'd0, 5'd0, 5'd8, 5'd5, 5'd16};
        cap_plan[5] = 5'($urandom_range(3, 15));
        cap_plan[6] = 5'($urandom_range(17, 30));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty cache, extreme keys and values, updates
        send_beat(OP_GET, 32'h0000_0000, 32'h1234_5678);
        send_beat(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_beat(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_beat(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_beat(OP_PUT, 32'h7FFF_FFFF, 32'hA5A5_5A5A);
        send_beat(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);

        // zero capacity acts as one, below the current fill
        set_capacity(5'd0);
        send_beat(OP_PUT, 32'h1234_5678, 32'h0F0F_0F0F);
        send_beat(OP_PUT, 32'h5A5A_5A5A, 32'hF0F0_F0F0);
        send_beat(OP_GET, 32'h1234_5678, 32'h0000_0000);
        send_beat(OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);
        send_beat(OP_GET, 32'h8000_0000, 32'h0000_0000);

        // capacity above the array size saturates
        set_capacity(5'd31);
        send_beat(OP_PUT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        send_beat(OP_GET, 32'hDEAD_BEEF, 32'h0000_0000);

        for (int phase = 0; phase < PHASES; phase++) begin
            set_capacity(cap_plan[phase]);
            if (cap_plan[phase] == 5'd0) begin
                eff = 1;
            end else if (cap_plan[phase] > 5'd16) begin
                eff = 16;
            end else begin
                eff = int'(cap_plan[phase]);
            end
            span = eff + $urandom_range(1, 6);
            if (span > POOL) begin
                span = POOL;
            end
            if (phase == PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = pct_choice[$urandom_range(0, 2)];
                stall_pct = pct_choice[$urandom_range(0, 2)];
            end
            repeat (PHASE_BEATS) begin
                op = t_op'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0) begin
                    k = $urandom;
                end else begin
                    k = key_pool[$urandom_range(0, span - 1)];
                end
                send_beat(op, k, $urandom);
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("lru_key_value_cache_top: match");
        end else begin
            $display("lru_key_value_cache_top: mismatch");
        end
        $finish;
    end

endmodule
